// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; they are empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset
`define BCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define BCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define BCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define BCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/bcs_pkg.sv
package bcs_pkg;

    // Field widths
    localparam int OFFSET_W = 40;
    localparam int LEN_W    = 32;
    localparam int CS_W     = 32;

    // Chunk size after reset
    localparam logic [CS_W-1:0] CHUNK_SIZE_RESET = 32'd1048576;

    // One quotient bit per division step
    localparam int DIV_STEPS = OFFSET_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_EMIT,
        ST_ERR
    } bcs_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_piece;
        logic emit_err;
    } bcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic len_zero;
        logic div_done;
        logic too_many;
        logic piece_last;
        logic out_free;
    } bcs_status_t;

endpackage

// File: rtl/core/bcs_ifs.sv
// Request channel
interface bcs_req_if import bcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] start_offset;
    logic [LEN_W-1:0]    length;

    modport source (output valid, start_offset, length, input ready);
    modport sink   (input valid, start_offset, length, output ready);
endinterface

// Result channel
interface bcs_rsp_if import bcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] chunk_num;
    logic [CS_W-1:0]     offset_in_chunk;
    logic [LEN_W-1:0]    piece_length;
    logic                last_piece;
    logic                too_many_pieces;

    modport source (output valid, chunk_num, offset_in_chunk, piece_length,
                    last_piece, too_many_pieces, input ready);
    modport sink   (input valid, chunk_num, offset_in_chunk, piece_length,
                    last_piece, too_many_pieces, output ready);
endinterface

// Configuration write channel
interface bcs_cfg_if import bcs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CS_W-1:0] chunk_size;

    modport source (output valid, chunk_size, input ready);
    modport sink   (input valid, chunk_size, output ready);
endinterface

// File: rtl/core/bcs_ctrl.sv
module bcs_ctrl import bcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bcs_status_t status,
    output bcs_cmd_t    cmd
);

    bcs_state_t state_reg;
    bcs_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.len_zero)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.too_many ? ST_ERR : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.piece_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit_piece = status.out_free;
            end
            ST_ERR:
            begin
                cmd.emit_err = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/bcs_dp.sv
module bcs_dp import bcs_pkg::*;
#(
    parameter int MAX_PIECES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OFFSET_W-1:0] start_offset,
    input  logic [LEN_W-1:0]    length,
    input  bcs_cmd_t            cmd,
    output bcs_status_t         status,
    bcs_rsp_if.source           rsp,
    bcs_cfg_if.sink             cfg
);

    // Limit on bytes after the first piece: (MAX_PIECES - 1) * chunk size
    localparam int LIM_W = CS_W + $clog2(MAX_PIECES);

    logic [CS_W-1:0]     cs_reg;
    logic [CS_W-1:0]     cs_eff_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [OFFSET_W-1:0] q_reg;
    logic [CS_W-1:0]     r_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_index_reg;
    logic [CS_W-1:0]     out_off_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;
    logic                out_err_reg;

    logic [CS_W-1:0]     cs_in;
    logic [CS_W:0]       shifted;
    logic                ge;
    logic [CS_W-1:0]     room;
    logic [LEN_W-1:0]    piece;
    logic [LEN_W-1:0]    rem_after;
    logic                out_free;

    // Configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= CHUNK_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            cs_reg <= cfg.chunk_size;
        end
    end

    // A chunk size of zero counts as one
    assign cs_in = (cs_reg == '0) ? CS_W'(1) : cs_reg;

    // Restoring division step: one quotient bit per cycle
    assign shifted = {r_reg, q_reg[OFFSET_W-1]};
    assign ge      = shifted >= {1'b0, cs_eff_reg};

    // Piece of the current chunk
    assign room      = cs_eff_reg - r_reg;
    assign piece     = (rem_reg < room) ? rem_reg : room;
    assign rem_after = rem_reg - piece;

    assign out_free = !out_valid_reg || rsp.ready;

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_eff_reg <= '0;
            lim_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            r_reg      <= '0;
        end
        else if (cmd.load)
        begin
            cs_eff_reg <= cs_in;
            lim_reg    <= LIM_W'(cs_in) * LIM_W'(MAX_PIECES - 1);
            rem_reg    <= length;
            q_reg      <= start_offset;
            r_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg <= {q_reg[OFFSET_W-2:0], ge};
            r_reg <= ge ? CS_W'(shifted - {1'b0, cs_eff_reg}) : CS_W'(shifted);
        end
        else if (cmd.emit_piece)
        begin
            rem_reg <= rem_after;
            q_reg   <= q_reg + OFFSET_W'(1);
            r_reg   <= '0;
        end
    end

    // Division step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_piece || cmd.emit_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_piece)
        begin
            out_index_reg <= q_reg;
            out_off_reg   <= r_reg;
            out_len_reg   <= piece;
            out_last_reg  <= (rem_after == '0);
            out_err_reg   <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_index_reg <= '0;
            out_off_reg   <= '0;
            out_len_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_err_reg   <= 1'b1;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.chunk_num       = out_index_reg;
    assign rsp.offset_in_chunk = out_off_reg;
    assign rsp.piece_length    = out_len_reg;
    assign rsp.last_piece      = out_last_reg;
    assign rsp.too_many_pieces = out_err_reg;

    // Status back to the controller
    always_comb
    begin
        status            = '0;
        status.len_zero   = (length == '0);
        status.div_done   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        status.too_many   = LIM_W'(rem_after) > lim_reg;
        status.piece_last = (rem_after == '0);
        status.out_free   = out_free;
    end

endmodule

// File: rtl/core/byte_range_chunk_splitter.sv
// Flow: a request is loaded in the idle state, run through the bit-serial divider
// (40 division steps), checked against the piece limit, then walked piece by piece
// into the output register. A new request is taken only in the idle state; one piece
// per cycle while the result channel is not stalling; zero length gives no result.
// Reset: rst_n asynchronous, active low; idle, chunk size back to 1048576.
`include "assert_macros.svh"

module byte_range_chunk_splitter import bcs_pkg::*;
#(
    parameter int MAX_PIECES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    bcs_req_if.sink   req,
    bcs_rsp_if.source rsp,
    bcs_cfg_if.sink   cfg
);

    bcs_cmd_t    cmd;
    bcs_status_t status;
    logic        in_ready;
    logic        req_fire;
    logic        err_out;

    assign req.ready = in_ready;

    // Sequencer
    bcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divider, piece walker and output register
    bcs_dp #(
        .MAX_PIECES (MAX_PIECES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_offset (req.start_offset),
        .length       (req.length),
        .cmd          (cmd),
        .status       (status),
        .rsp          (rsp),
        .cfg          (cfg)
    );

    // Checks
    assign req_fire = req.valid && req.ready;
    assign err_out  = rsp.valid && rsp.too_many_pieces;

    `BCS_ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
    `BCS_ASSERT_NEXT(a_err_result, clk, rst_n, cmd.emit_err, err_out && rsp.last_piece)
    `BCS_ASSERT_SAME(a_err_zero, clk, rst_n, err_out, rsp.piece_length == '0 && rsp.chunk_num == '0)
    `BCS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_fire && req.length != '0, !req.ready)

endmodule

// File: tb/byte_range_chunk_splitter_test.sv
module byte_range_chunk_splitter_test;
    import bcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIECES    = 64;
    // Division plus check plus output load, with margin
    localparam int SETTLE_CYCLES = 60;

    // One expected piece as the result channel carries it
    typedef struct packed {
        logic [OFFSET_W-1:0] chunk_num;
        logic [CS_W-1:0]     offset_in_chunk;
        logic [LEN_W-1:0]    piece_length;
        logic                last_piece;
        logic                too_many_pieces;
    } piece_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    bcs_req_if req_ch ();
    bcs_rsp_if rsp_ch ();
    bcs_cfg_if cfg_ch ();

    byte_range_chunk_splitter #(.MAX_PIECES(MAX_PIECES)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the chunk size register and pieces still owed by the block
    logic [CS_W-1:0] chunk_size_shadow;
    piece_rec_t      pending_pieces[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int n_requests     = 0;
    int n_pieces       = 0;
    int n_overflow     = 0;
    int n_cfg_writes   = 0;

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #40ms;
        $display("timeout: %0d pieces still pending", pending_pieces.size());
        $display("byte_range_chunk_splitter_test: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Split one request into the pieces the block should produce
    function automatic void split_request(input logic [OFFSET_W-1:0] start,
                                          input logic [LEN_W-1:0] len);
        logic [63:0]         cs;
        logic [63:0]         first_off;
        logic [63:0]         first_len;
        logic [63:0]         pieces;
        logic [63:0]         rem;
        logic [63:0]         room;
        logic [63:0]         piece;
        logic [OFFSET_W-1:0] idx;
        logic [CS_W-1:0]     off;
        piece_rec_t          p;
        if (len == '0)
            return;
        // register value zero behaves as one
        cs        = (chunk_size_shadow == '0) ? 64'd1 : {32'd0, chunk_size_shadow};
        first_off = {24'd0, start} % cs;
        first_len = cs - first_off;
        if (first_len > {32'd0, len})
            first_len = {32'd0, len};
        pieces = 64'd1 + ({32'd0, len} - first_len + cs - 64'd1) / cs;
        if (pieces > MAX_PIECES)
        begin
            p = '0;
            p.last_piece      = 1'b1;
            p.too_many_pieces = 1'b1;
            pending_pieces = {pending_pieces, p};
            n_overflow++;
            return;
        end
        idx = OFFSET_W'({24'd0, start} / cs);
        off = first_off[CS_W-1:0];
        rem = {32'd0, len};
        for (int k = 0; k < MAX_PIECES; k++)
        begin
            room  = cs - {32'd0, off};
            piece = (rem < room) ? rem : room;
            rem   = rem - piece;
            p.chunk_num       = idx;
            p.offset_in_chunk = off;
            p.piece_length    = piece[LEN_W-1:0];
            p.last_piece      = (rem == 64'd0);
            p.too_many_pieces = 1'b0;
            pending_pieces = {pending_pieces, p};
            if (rem == 64'd0)
                break;
            // index wraps at the top of the 40-bit space
            idx = idx + OFFSET_W'(1);
            off = '0;
        end
    endfunction

    // Result receiver: random back-pressure per phase
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker
    initial
    begin
        piece_rec_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                n_pieces++;
                if (pending_pieces.size() == 0)
                    report_mismatch("piece with nothing pending, chunk_num",
                                    64'(rsp_ch.chunk_num), '0);
                else
                begin
                    want = pending_pieces.pop_front();
                    if (rsp_ch.chunk_num !== want.chunk_num)
                        report_mismatch("chunk_num", 64'(rsp_ch.chunk_num),
                                        64'(want.chunk_num));
                    if (rsp_ch.offset_in_chunk !== want.offset_in_chunk)
                        report_mismatch("offset_in_chunk", 64'(rsp_ch.offset_in_chunk),
                                        64'(want.offset_in_chunk));
                    if (rsp_ch.piece_length !== want.piece_length)
                        report_mismatch("piece_length", 64'(rsp_ch.piece_length),
                                        64'(want.piece_length));
                    if (rsp_ch.last_piece !== want.last_piece)
                        report_mismatch("last_piece", 64'(rsp_ch.last_piece),
                                        64'(want.last_piece));
                    if (rsp_ch.too_many_pieces !== want.too_many_pieces)
                        report_mismatch("too_many_pieces", 64'(rsp_ch.too_many_pieces),
                                        64'(want.too_many_pieces));
                end
            end
        end
    end

    // Send one request; valid stays high after acceptance until the next
    // caller either replaces the payload or lowers it
    task automatic send_request(input logic [OFFSET_W-1:0] start,
                                input logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.start_offset <= start;
        req_ch.length       <= len;
        do
            @(posedge clk);
        while (!req_ch.ready);
        split_request(start, len);
        n_requests++;
    endtask

    // Hold off requests until every owed piece has come, then let the block settle
    task automatic wait_for_pieces();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_pieces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chunk_size(input logic [CS_W-1:0] value);
        wait_for_pieces();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.chunk_size <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        chunk_size_shadow = value;
        n_cfg_writes++;
    endtask

    function automatic logic [OFFSET_W-1:0] rand_offset();
        return {8'($urandom_range(0, 255)), $urandom};
    endfunction

    function automatic logic [CS_W-1:0] pick_chunk_size();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 16);
            1: return 32'd1 << $urandom_range(0, 31);
            2: return $urandom;
            3: return '0;
            4: return 32'hFFFF_FFFF;
            default: return $urandom_range(100, 100000);
        endcase
    endfunction

    // Mostly requests that fit within the piece limit, plus noise
    task automatic send_random_request();
        logic [63:0] cs;
        logic [63:0] span;
        logic [63:0] start64;
        logic [63:0] len64;
        int          n;
        cs      = (chunk_size_shadow == '0) ? 64'd1 : {32'd0, chunk_size_shadow};
        start64 = {24'd0, rand_offset()};
        n       = $urandom_range(1, MAX_PIECES);
        span    = cs * n;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        len64 = 64'd1 + ({$urandom, $urandom} % span);
        case ($urandom_range(0, 9))
            0, 1, 2:
                ;
            3, 4:
                // start on a chunk boundary
                start64 = start64 - (start64 % cs);
            5:
                // start on the last byte of a chunk
                start64 = start64 - (start64 % cs) + cs - 64'd1;
            6:
                len64 = 64'd0;
            7:
                len64 = {32'd0, $urandom};
            8:
            begin
                // just past the piece limit where the length allows it
                len64 = cs * (MAX_PIECES + $urandom_range(0, 2)) + 64'd1;
                if (len64 > 64'hFFFF_FFFF)
                    len64 = 64'hFFFF_FFFF;
            end
            default:
                // near the top of the offset space
                start64 = 64'hFF_FFFF_FFFF - ({$urandom, $urandom} % (cs * 2));
        endcase
        send_request(start64[OFFSET_W-1:0], len64[LEN_W-1:0]);
    endtask

    // Chunk size as left by reset
    task automatic test_reset_chunk_size();
        send_request(40'd0, 32'd1);
        send_request(40'd0, 32'd1048576);
        send_request(40'd1048575, 32'd2);
        send_request(40'd12345, 32'd0);
        send_request(40'hFF_FFFF_FFFF, 32'd1);
    endtask

    // Piece limit and full-width fields
    task automatic test_piece_limit();
        write_chunk_size(32'd1048576);
        send_request(40'd0, 32'd64 * 32'd1048576);
        send_request(40'd1, 32'd64 * 32'd1048576);
        send_request(40'd0, 32'hFFFF_FFFF);
        send_request(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Zero register value acts as one byte per chunk; index wraps
    task automatic test_zero_chunk_size();
        write_chunk_size('0);
        send_request(40'hFF_FFFF_FFFE, 32'd4);
        send_request(40'd7, 32'd64);
        send_request(40'd7, 32'd65);
        send_request(40'd7, 32'd0);
        write_chunk_size(32'd1);
        send_request(40'hFF_FFFF_FFC0, 32'd64);
        write_chunk_size(32'd3);
        send_request(40'd5, 32'd10);
    endtask

    // Widest chunk size
    task automatic test_widest_chunk();
        write_chunk_size(32'hFFFF_FFFF);
        send_request(40'd0, 32'hFFFF_FFFF);
        send_request(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(40'hFFFF_FFFE, 32'd2);
        send_request(40'h55_5555_5555, 32'hAAAA_AAAA);
    endtask

    // Random requests under each idling pattern
    task automatic test_random_phases();
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int k = 0; k < 2; k++)
            begin
                write_chunk_size(pick_chunk_size());
                repeat (22) send_random_request();
            end
        end
    endtask

    // Sender stops until the block has delivered everything, then resumes
    task automatic test_pause_until_drained();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        write_chunk_size($urandom_range(1, 64));
        repeat (4) send_random_request();
        wait_for_pieces();
        repeat (4) send_random_request();
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.start_offset <= '0;
        req_ch.length       <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.chunk_size   <= '0;
        chunk_size_shadow    = CHUNK_SIZE_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_chunk_size();
        test_piece_limit();
        test_zero_chunk_size();
        test_widest_chunk();
        test_random_phases();
        test_pause_until_drained();

        wait_for_pieces();
        $display("covered %0d requests and %0d pieces, %0d of them overflow results",
                 n_requests, n_pieces, n_overflow);
        $display("%0d chunk size writes, four idling patterns plus a drained pause",
                 n_cfg_writes);
        if (errors == 0)
            $display("byte_range_chunk_splitter_test: clean");
        else
            $display("byte_range_chunk_splitter_test: errors");
        $finish;
    end

endmodule
